[rtl/mesh_route_table_engine_defines.svh]
// Assertion macros used by the checker file of the route table engine.
`ifndef MESH_ROUTE_TABLE_ENGINE_DEFINES_SVH
`define MESH_ROUTE_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mrte_pkg.sv]
package mrte_pkg;

	// Reserved link addresses.
	localparam logic [31:0] ADDR_ROUTING   = 32'hAFFF_FFFF;
	localparam logic [31:0] ADDR_BROADCAST = 32'hFFFF_FFFF;
	localparam logic [31:0] ADDR_LOOPBACK  = 32'h0000_0000;

	localparam logic [3:0] SCORE_MAX    = 4'hF;
	localparam logic [7:0] FAR_DISTANCE = 8'd255;
	localparam logic [7:0] DIST_NEIGHBOR = 8'd1;
	localparam logic [7:0] DIST_RECEIVER = 8'd2;

	localparam logic OP_LEARN = 1'b0;
	localparam logic OP_ROUTE = 1'b1;

	// Route offers, in the order they are made for one learn item.
	localparam logic [1:0] OFF_SENDER   = 2'd0;
	localparam logic [1:0] OFF_RECEIVER = 2'd1;
	localparam logic [1:0] OFF_SOURCE   = 2'd2;
	localparam logic [1:0] OFF_DEST     = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NB_RD,
		ST_NB_CMP,
		ST_NB_UPD,
		ST_OFF_SEL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RT_RD,
		ST_RT_CMP,
		ST_FND_SEL,
		ST_FD_RD,
		ST_FD_CMP,
		ST_OUT
	} state_t;

	// Address equality on the bytes selected by the mask.
	function automatic logic same_addr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] m);
		return ((a ^ b) & m) == 32'd0;
	endfunction

	// New link byte from the previous byte, previous sequence and new sequence.
	function automatic logic [7:0] link_byte(input logic [7:0] pb, input logic [7:0] ps,
			input logic [7:0] seq);
		logic [3:0] score;
		logic [7:0] gap;
		logic [7:0] gm1;
		logic [3:0] n;
		score = pb[7:4];
		gap = seq - ps;
		gm1 = gap - 8'd1;
		n = 4'd0;
		if (gap == 8'd1) begin
			n = (score < SCORE_MAX) ? score + 4'd1 : SCORE_MAX;
		end else if (gap != 8'd0 && {4'd0, score} > gm1) begin
			n = score - gm1[3:0];
		end
		return (n == 4'd0) ? 8'd0 : {n, SCORE_MAX};
	endfunction

endpackage

[rtl/mrte_ram.sv]
module mrte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/mrte_div.sv]
module mrte_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic        done,
	output logic [15:0] quot
);

	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [7:0]  den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  trial;
	logic        ge;

	// One restoring step: shift in the next numerator bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[15]};
		ge = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 8'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[rtl/mesh_route_table_engine.sv]
// Neighbor and route table engine for a mesh link layer.
// Input channel (in_valid/in_ready) takes one item: opcode 0 learns from a
// received header, opcode 1 asks for the next hop of a datagram. Output
// channel (out_valid/out_ready) returns exactly one result item per input item.
// The user must write the local address through cfg_write_enable/cfg_write_data
// only while idle; the block does not enforce this. Items are handled one at a
// time; in_ready is high only while the sequencer idles. A learn item scans the
// neighbor table, then makes up to four route offers, each scanning the route
// table; the source offer adds a serial division of 16 steps. Each scan reads
// one entry at a time through the single read port of its table memory and the
// shared address comparator. The result sits in an output register: when the
// receiver stalls, the block still takes and works on the next item, and waits
// only before writing its result over one not yet taken. Reset empties both
// tables at once by clearing their counts; there is no clearing pass.
module mesh_route_table_engine #(
	parameter int NEIGHBOR_SLOTS = 32,
	parameter int ROUTE_SLOTS = 64,
	parameter int ADDRESS_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] sender_address,
	input  logic [31:0] receiver_address,
	input  logic [31:0] source_address,
	input  logic [31:0] destination_address,
	input  logic [7:0]  sequence_req,
	input  logic [7:0]  hop_count,
	input  logic [7:0]  path_metric,
	input  logic [7:0]  time_to_live,
	input  logic        allow_broadcast,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  neighbor_index,
	output logic [7:0]  link_metric,
	output logic [6:0]  route_count,
	output logic [3:0]  routes_updated,
	output logic        table_full,
	output logic        send,
	output logic [31:0] next_hop,
	output logic [7:0]  route_metric
);

	import mrte_pkg::*;

	localparam int NA_W = $clog2(NEIGHBOR_SLOTS);
	localparam int RA_W = $clog2(ROUTE_SLOTS);
	localparam int NCW = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int RCW = $clog2(ROUTE_SLOTS + 1);
	localparam int MAXS = (NEIGHBOR_SLOTS > ROUTE_SLOTS) ? NEIGHBOR_SLOTS : ROUTE_SLOTS;
	localparam int IW = $clog2(MAXS + 1);
	localparam logic [31:0] ADDR_MASK = (ADDRESS_BYTES >= 4) ? 32'hFFFF_FFFF :
		~(32'hFFFF_FFFF >> (8 * ADDRESS_BYTES));

	state_t state_q, state_d;

	logic [31:0] local_q;
	logic [31:0] snd_q, rcv_q, src_q, dst_q;
	logic [7:0]  seq_q, hops_q, pm_q, ttl_q;
	logic        op_q, bc_q;
	logic [NCW-1:0] nb_cnt_q;
	logic [RCW-1:0] rt_cnt_q;
	logic [IW-1:0]  idx_q;
	logic            found_q;
	logic [NA_W-1:0] slot_q, nidx_q;
	logic [7:0]  pb_q, ps_q, link_q;
	logic        full_q;
	logic [3:0]  mask_q;
	logic [1:0]  off_q;
	logic [31:0] key_q, via_q;
	logic [7:0]  dist_q, qual_q;
	logic [15:0] prod_q;
	logic        fnd_dst_q, hit_q, send_q;
	logic [7:0]  met_q, rmet_q;
	logic [31:0] hop_q;
	logic        out_valid_q;
	logic [4:0]  o_nidx_q;
	logic [7:0]  o_link_q, o_rmet_q;
	logic [6:0]  o_cnt_q;
	logic [3:0]  o_mask_q;
	logic        o_full_q, o_send_q;
	logic [31:0] o_hop_q;

	logic [47:0] nb_rdata, nb_wdata;
	logic [79:0] rt_rdata, rt_wdata;
	logic        nb_we, rt_we;
	logic [NA_W-1:0] nb_waddr;
	logic [RA_W-1:0] rt_waddr;
	logic        div_start, div_done;
	logic [15:0] div_quot;

	logic [31:0] cmp_addr;
	logic        key_hit;
	logic        nb_end, rt_end, nb_room, rt_room;
	logic [7:0]  link_c, d_val;
	logic        routing, off_app, off_local, off_last, accept_c, out_free;
	logic [31:0] off_dest;
	logic [7:0]  off_dist, off_qual;

	// Table memories.
	mrte_ram #(.WIDTH(48), .DEPTH(NEIGHBOR_SLOTS)) u_nb_ram (
		.clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
		.raddr(idx_q[NA_W-1:0]), .rdata(nb_rdata)
	);

	mrte_ram #(.WIDTH(80), .DEPTH(ROUTE_SLOTS)) u_rt_ram (
		.clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
		.raddr(idx_q[RA_W-1:0]), .rdata(rt_rdata)
	);

	// Serial divider for the hop-averaged source metric.
	mrte_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(16'(link_q) + prod_q), .den(dist_q),
		.done(div_done), .quot(div_quot)
	);

	// Shared address comparator and per-state helper terms.
	always_comb begin
		cmp_addr = (state_q == ST_NB_CMP) ? nb_rdata[47:16] : rt_rdata[79:48];
		key_hit = same_addr(key_q, cmp_addr, ADDR_MASK);
		nb_end = idx_q >= IW'(nb_cnt_q);
		rt_end = idx_q >= IW'(rt_cnt_q);
		nb_room = nb_cnt_q < NCW'(NEIGHBOR_SLOTS);
		rt_room = rt_cnt_q < RCW'(ROUTE_SLOTS);
		link_c = found_q ? link_byte(pb_q, ps_q, seq_q) : link_byte(8'd0, 8'd0, seq_q);
		d_val = (hops_q == FAR_DISTANCE) ? FAR_DISTANCE : hops_q + 8'd1;
		routing = same_addr(rcv_q, ADDR_ROUTING, ADDR_MASK);
		off_last = off_q == OFF_DEST;
		out_free = !out_valid_q || out_ready;
		accept_c = same_addr(via_q, rt_rdata[47:16], ADDR_MASK) ||
			(dist_q < rt_rdata[15:8]) ||
			(dist_q == rt_rdata[15:8] && qual_q > rt_rdata[7:0]);
	end

	// Candidate route for the current offer.
	always_comb begin
		off_dest = snd_q;
		off_dist = DIST_NEIGHBOR;
		off_qual = link_q;
		off_app = 1'b1;
		unique case (off_q)
			OFF_SENDER: begin
				off_app = 1'b1;
			end
			OFF_RECEIVER: begin
				off_dest = rcv_q;
				off_dist = DIST_RECEIVER;
				off_qual = 8'd0;
				off_app = !routing && !same_addr(rcv_q, local_q, ADDR_MASK) &&
					!same_addr(rcv_q, ADDR_BROADCAST, ADDR_MASK);
			end
			OFF_SOURCE: begin
				off_dest = src_q;
				off_dist = d_val;
				off_qual = 8'd0;
				off_app = !routing && !same_addr(snd_q, src_q, ADDR_MASK);
			end
			OFF_DEST: begin
				off_dest = dst_q;
				off_dist = FAR_DISTANCE;
				off_qual = 8'd0;
				off_app = !routing && !same_addr(dst_q, local_q, ADDR_MASK) &&
					!same_addr(dst_q, rcv_q, ADDR_MASK) &&
					!same_addr(dst_q, ADDR_BROADCAST, ADDR_MASK);
			end
			default: begin
				off_app = 1'b0;
			end
		endcase
		off_local = same_addr(off_dest, local_q, ADDR_MASK);
	end

	// Sequencer: next state and memory and divider controls.
	always_comb begin
		state_d = state_q;
		nb_we = 1'b0;
		rt_we = 1'b0;
		div_start = 1'b0;
		nb_waddr = found_q ? slot_q : nb_cnt_q[NA_W-1:0];
		nb_wdata = {snd_q, link_c, seq_q};
		rt_waddr = (state_q == ST_RT_RD) ? rt_cnt_q[RA_W-1:0] : idx_q[RA_W-1:0];
		rt_wdata = {key_q, via_q, dist_q, qual_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_LEARN) begin
						state_d = ST_NB_RD;
					end else if (time_to_live == 8'd0) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_FND_SEL;
					end
				end
			end
			ST_NB_RD: begin
				state_d = nb_end ? ST_NB_UPD : ST_NB_CMP;
			end
			ST_NB_CMP: begin
				state_d = ST_NB_RD;
			end
			ST_NB_UPD: begin
				nb_we = found_q || nb_room;
				state_d = ST_OFF_SEL;
			end
			ST_OFF_SEL: begin
				if (!off_app || off_local) begin
					state_d = off_last ? ST_OUT : ST_OFF_SEL;
				end else if (off_q == OFF_SOURCE) begin
					state_d = ST_DIV_GO;
				end else begin
					state_d = ST_RT_RD;
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_RT_RD;
				end
			end
			ST_RT_RD: begin
				if (rt_end) begin
					rt_we = rt_room;
					state_d = off_last ? ST_OUT : ST_OFF_SEL;
				end else begin
					state_d = ST_RT_CMP;
				end
			end
			ST_RT_CMP: begin
				if (key_hit) begin
					rt_we = accept_c;
					state_d = off_last ? ST_OUT : ST_OFF_SEL;
				end else begin
					state_d = ST_RT_RD;
				end
			end
			ST_FND_SEL: begin
				if (!fnd_dst_q) begin
					state_d = same_addr(src_q, local_q, ADDR_MASK) ? ST_FND_SEL : ST_FD_RD;
				end else if (same_addr(dst_q, ADDR_LOOPBACK, ADDR_MASK) ||
						same_addr(dst_q, ADDR_BROADCAST, ADDR_MASK)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_FD_RD;
				end
			end
			ST_FD_RD: begin
				if (rt_end) begin
					state_d = fnd_dst_q ? ST_OUT : ST_FND_SEL;
				end else begin
					state_d = ST_FD_CMP;
				end
			end
			ST_FD_CMP: begin
				state_d = ST_FD_RD;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, table counts and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= 32'd0;
			nb_cnt_q <= '0;
			rt_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				local_q <= cfg_write_data;
			end
			if (state_q == ST_NB_UPD && !found_q && nb_room) begin
				nb_cnt_q <= nb_cnt_q + NCW'(1);
			end
			if (state_q == ST_RT_RD && rt_end && rt_room) begin
				rt_cnt_q <= rt_cnt_q + RCW'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the item under way.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q <= opcode;
				snd_q <= sender_address;
				rcv_q <= receiver_address;
				src_q <= source_address;
				dst_q <= destination_address;
				seq_q <= sequence_req;
				hops_q <= hop_count;
				pm_q <= path_metric;
				ttl_q <= time_to_live;
				bc_q <= allow_broadcast;
				key_q <= sender_address;
				idx_q <= '0;
				found_q <= 1'b0;
				full_q <= 1'b0;
				mask_q <= 4'd0;
				off_q <= OFF_SENDER;
				link_q <= 8'd0;
				nidx_q <= '0;
				fnd_dst_q <= 1'b0;
				hit_q <= 1'b0;
				met_q <= 8'd0;
				send_q <= 1'b0;
				hop_q <= 32'd0;
				rmet_q <= 8'd0;
			end
			ST_NB_RD: begin
			end
			ST_NB_CMP: begin
				if (key_hit) begin
					found_q <= 1'b1;
					slot_q <= idx_q[NA_W-1:0];
					pb_q <= nb_rdata[15:8];
					ps_q <= nb_rdata[7:0];
				end
				idx_q <= idx_q + IW'(1);
			end
			ST_NB_UPD: begin
				link_q <= link_c;
				if (found_q) begin
					nidx_q <= slot_q;
				end else if (nb_room) begin
					nidx_q <= nb_cnt_q[NA_W-1:0];
				end else begin
					full_q <= 1'b1;
				end
			end
			ST_OFF_SEL: begin
				if (!off_app || off_local) begin
					off_q <= off_q + 2'd1;
				end else begin
					key_q <= off_dest;
					via_q <= snd_q;
					dist_q <= off_dist;
					qual_q <= off_qual;
					idx_q <= '0;
					prod_q <= 16'(pm_q) * 16'(d_val - 8'd1);
				end
			end
			ST_DIV_GO: begin
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					qual_q <= div_quot[7:0];
				end
			end
			ST_RT_RD: begin
				if (rt_end) begin
					if (rt_room) begin
						mask_q[off_q] <= 1'b1;
					end else begin
						full_q <= 1'b1;
					end
					off_q <= off_q + 2'd1;
				end
			end
			ST_RT_CMP: begin
				if (key_hit) begin
					if (accept_c) begin
						mask_q[off_q] <= 1'b1;
					end
					off_q <= off_q + 2'd1;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ST_FND_SEL: begin
				idx_q <= '0;
				hit_q <= 1'b0;
				if (!fnd_dst_q) begin
					key_q <= src_q;
					if (same_addr(src_q, local_q, ADDR_MASK)) begin
						fnd_dst_q <= 1'b1;
					end
				end else begin
					key_q <= dst_q;
					if (same_addr(dst_q, ADDR_BROADCAST, ADDR_MASK) &&
							!same_addr(dst_q, ADDR_LOOPBACK, ADDR_MASK) && bc_q) begin
						send_q <= 1'b1;
						hop_q <= ADDR_BROADCAST;
						rmet_q <= met_q;
					end
				end
			end
			ST_FD_RD: begin
				if (rt_end) begin
					if (!fnd_dst_q) begin
						fnd_dst_q <= 1'b1;
					end else if (hit_q) begin
						send_q <= 1'b1;
						rmet_q <= met_q;
					end
				end
			end
			ST_FD_CMP: begin
				if (key_hit) begin
					hit_q <= 1'b1;
					if (fnd_dst_q) begin
						hop_q <= rt_rdata[47:16];
					end else begin
						met_q <= rt_rdata[7:0];
					end
				end
				idx_q <= idx_q + IW'(1);
			end
			ST_OUT: begin
				if (out_free) begin
					o_nidx_q <= (op_q == OP_LEARN) ? 5'(nidx_q) : 5'd0;
					o_link_q <= link_q;
					o_cnt_q <= 7'(rt_cnt_q);
					o_mask_q <= mask_q;
					o_full_q <= full_q;
					o_send_q <= send_q && (ttl_q != 8'd0);
					o_hop_q <= hop_q;
					o_rmet_q <= rmet_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign neighbor_index = o_nidx_q;
	assign link_metric = o_link_q;
	assign route_count = o_cnt_q;
	assign routes_updated = o_mask_q;
	assign table_full = o_full_q;
	assign send = o_send_q;
	assign next_hop = o_hop_q;
	assign route_metric = o_rmet_q;

endmodule

[rtl/mrte_checker.sv]
`include "mesh_route_table_engine_defines.svh"

module mrte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  link_metric,
	input logic        send,
	input logic [31:0] next_hop,
	input logic [7:0]  route_metric
);

	// A result item waiting for the receiver stays offered.
	`MRTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")

	// The sequencer leaves idle as soon as it takes an item.
	`MRTE_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

	// A result that sends nothing carries no next hop and no metric.
	`MRTE_ASSERT_IMP(a_no_send_zero, out_valid && !send, next_hop == 32'd0 && route_metric == 8'd0, "stray hop")

	// A nonzero link byte always has its low nibble set.
	`MRTE_ASSERT_IMP(a_link_form, out_valid && link_metric != 8'd0, link_metric[3:0] == 4'hF, "bad link byte")

endmodule

bind mesh_route_table_engine mrte_checker u_mrte_checker (.*);
